>>> rtl/rsqv_pkg.sv
// Shared constants and the CORDIC arctangent table for the sprite quad corner pipeline.
package rsqv_pkg;
  localparam int COORD_BITS_DEF = 24;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int CORDIC_STEPS   = 28;
  localparam int STEP_BITS      = 5;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [32:0] ONE_Q30     = 33'sd1073741824;

  // Angle of each micro-rotation, 2^32 is one turn.
  function automatic logic [31:0] atan_turn(input logic [STEP_BITS-1:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0:  r = 32'd536870912;
        5'd1:  r = 32'd316933406;
        5'd2:  r = 32'd167458907;
        5'd3:  r = 32'd85004756;
        5'd4:  r = 32'd42667331;
        5'd5:  r = 32'd21354465;
        5'd6:  r = 32'd10679838;
        5'd7:  r = 32'd5340245;
        5'd8:  r = 32'd2670163;
        5'd9:  r = 32'd1335087;
        5'd10: r = 32'd667544;
        5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;
        5'd13: r = 32'd83443;
        5'd14: r = 32'd41722;
        5'd15: r = 32'd20861;
        5'd16: r = 32'd10430;
        5'd17: r = 32'd5215;
        5'd18: r = 32'd2608;
        5'd19: r = 32'd1304;
        5'd20: r = 32'd652;
        5'd21: r = 32'd326;
        5'd22: r = 32'd163;
        5'd23: r = 32'd81;
        5'd24: r = 32'd41;
        5'd25: r = 32'd20;
        5'd26: r = 32'd10;
        5'd27: r = 32'd5;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction
endpackage

>>> rtl/rsqv_atan.sv
// Pipelined vectoring CORDIC, one step per stage: angle of the centre against the up axis in radial mode, else spin.
module rsqv_atan #(
  parameter int COORD_BITS = rsqv_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = rsqv_pkg::ANGLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic                         radial,
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cy,
  input  logic        [ANGLE_BITS-1:0] spin,
  output logic                         out_valid,
  output logic        [31:0]           theta
);
  import rsqv_pkg::*;
  localparam int VW = COORD_BITS + 32;
  localparam int N  = CORDIC_STEPS + 1;

  logic signed [VW-1:0] u_r [N];
  logic signed [VW-1:0] v_r [N];
  logic        [31:0]   z_r [N];
  logic                 rad_r [N];
  logic                 zero_r [N];
  logic        [31:0]   spin_r [N];
  logic                 vld_r [N];

  logic signed [VW-1:0] u0, v0;
  always_comb begin
    u0 = VW'(cy) <<< 29;
    v0 = VW'(cx) <<< 29;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < N; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r[0]  <= radial;
      zero_r[0] <= (cx == '0) && (cy == '0);
      spin_r[0] <= {spin, {(32-ANGLE_BITS){1'b0}}};
      if (u0 < 0) begin
        u_r[0] <= -u0;
        v_r[0] <= -v0;
        z_r[0] <= 32'h8000_0000;
      end else begin
        u_r[0] <= u0;
        v_r[0] <= v0;
        z_r[0] <= '0;
      end
      for (int k = 1; k < N; k++) begin
        rad_r[k]  <= rad_r[k-1];
        zero_r[k] <= zero_r[k-1];
        spin_r[k] <= spin_r[k-1];
        if (v_r[k-1] > 0) begin
          u_r[k] <= u_r[k-1] + (v_r[k-1] >>> (k-1));
          v_r[k] <= v_r[k-1] - (u_r[k-1] >>> (k-1));
          z_r[k] <= z_r[k-1] + atan_turn(STEP_BITS'(k-1));
        end else begin
          u_r[k] <= u_r[k-1] - (v_r[k-1] >>> (k-1));
          v_r[k] <= v_r[k-1] + (u_r[k-1] >>> (k-1));
          z_r[k] <= z_r[k-1] - atan_turn(STEP_BITS'(k-1));
        end
      end
    end
  end

  assign out_valid = vld_r[N-1];
  assign theta = !rad_r[N-1] ? spin_r[N-1] : (zero_r[N-1] ? 32'd0 : z_r[N-1]);
endmodule

>>> rtl/rsqv_sincos.sv
// Pipelined rotation CORDIC: cosine and sine in Q30 of the negated angle.
module rsqv_sincos (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [31:0]        theta,
  output logic               out_valid,
  output logic signed [31:0] cos_q30,
  output logic signed [31:0] sin_q30
);
  import rsqv_pkg::*;
  localparam int N = CORDIC_STEPS + 1;

  logic signed [32:0] x_r [N];
  logic signed [32:0] y_r [N];
  logic signed [32:0] z_r [N];
  logic               flip_r [N];
  logic               vld_r [N];
  logic signed [31:0] c_r, s_r;
  logic               ov_r;

  logic [31:0] phi, phf;
  logic        flp;
  always_comb begin
    phi = 32'd0 - theta;
    flp = (phi[31:30] == 2'd1) || (phi[31:30] == 2'd2);
    phf = flp ? phi + 32'h8000_0000 : phi;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N; k++) vld_r[k] <= 1'b0;
      ov_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < N; k++) vld_r[k] <= vld_r[k-1];
      ov_r <= vld_r[N-1];
    end
  end

  logic signed [32:0] xc, yc;
  always_comb begin
    xc = x_r[N-1];
    yc = y_r[N-1];
    if (xc > ONE_Q30) xc = ONE_Q30;
    if (xc < -ONE_Q30) xc = -ONE_Q30;
    if (yc > ONE_Q30) yc = ONE_Q30;
    if (yc < -ONE_Q30) yc = -ONE_Q30;
    if (flip_r[N-1]) begin
      xc = -xc;
      yc = -yc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= CORDIC_GAIN;
      y_r[0]    <= '0;
      z_r[0]    <= {phf[31], phf};
      flip_r[0] <= flp;
      for (int k = 1; k < N; k++) begin
        flip_r[k] <= flip_r[k-1];
        if (!z_r[k-1][32]) begin
          x_r[k] <= x_r[k-1] - (y_r[k-1] >>> (k-1));
          y_r[k] <= y_r[k-1] + (x_r[k-1] >>> (k-1));
          z_r[k] <= z_r[k-1] - $signed({1'b0, atan_turn(STEP_BITS'(k-1))});
        end else begin
          x_r[k] <= x_r[k-1] + (y_r[k-1] >>> (k-1));
          y_r[k] <= y_r[k-1] - (x_r[k-1] >>> (k-1));
          z_r[k] <= z_r[k-1] + $signed({1'b0, atan_turn(STEP_BITS'(k-1))});
        end
      end
      c_r <= xc[31:0];
      s_r <= yc[31:0];
    end
  end

  assign out_valid = ov_r;
  assign cos_q30   = c_r;
  assign sin_q30   = s_r;
endmodule

>>> rtl/rsqv_corners.sv
// Multiply edge length by cos/sin, form offsets, halve and round, add centre and saturate.
module rsqv_corners #(
  parameter int COORD_BITS = rsqv_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic        [COORD_BITS-2:0] h,
  input  logic signed [31:0]           cos_q30,
  input  logic signed [31:0]           sin_q30,
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cy,
  output logic                         out_valid,
  output logic [8*COORD_BITS-1:0]      corners
);
  localparam int PW = COORD_BITS + 32;
  localparam int SW = PW + 2;
  localparam int RW = SW - 31 + 1;

  logic               v1_r, v2_r, v3_r;
  logic signed [PW-1:0] p_r, q_r;
  logic signed [COORD_BITS-1:0] cx1_r, cy1_r, cx2_r, cy2_r;
  logic signed [RW-1:0] a_r, b_r, c_r, d_r;
  logic [8*COORD_BITS-1:0] o_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  function automatic logic signed [RW-1:0] rnd(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    begin
      t = v + (SW'(1) <<< 30);
      return RW'(t >>> 31);
    end
  endfunction

  function automatic logic [COORD_BITS-1:0] sat(input logic signed [COORD_BITS-1:0] c,
                                                input logic signed [RW-1:0] o);
    logic signed [RW:0] s;
    logic signed [RW:0] hi, lo;
    begin
      hi = (RW+1)'((64'sd1 <<< (COORD_BITS-1)) - 1);
      lo = -hi - 1;
      s  = (RW+1)'(c) + (RW+1)'(o);
      if (s > hi) s = hi;
      if (s < lo) s = lo;
      return s[COORD_BITS-1:0];
    end
  endfunction

  logic signed [SW-1:0] pe, qe;
  always_comb begin
    pe = SW'(p_r);
    qe = SW'(q_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r   <= $signed({1'b0, h}) * cos_q30;
      q_r   <= $signed({1'b0, h}) * sin_q30;
      cx1_r <= cx;
      cy1_r <= cy;
      // a = q-p, b = -(p+q), c = p+q, d = p-q
      a_r   <= rnd(qe - pe);
      b_r   <= rnd(-(pe + qe));
      c_r   <= rnd(pe + qe);
      d_r   <= rnd(pe - qe);
      cx2_r <= cx1_r;
      cy2_r <= cy1_r;
      o_r   <= {sat(cy2_r, c_r), sat(cx2_r, d_r), sat(cy2_r, d_r), sat(cx2_r, b_r),
                sat(cy2_r, a_r), sat(cx2_r, c_r), sat(cy2_r, b_r), sat(cx2_r, a_r)};
    end
  end

  assign out_valid = v3_r;
  assign corners   = o_r;
endmodule

>>> rtl/rotated_sprite_quad_vertices.sv
// Top level: sprite quad corner pipeline with stream handshake and output register.
// Stages: 29 atan2 stages, 30 sin/cos stages, 3 corner stages and 1 output register; one
// transaction per cycle while the output is not stalled, as the CORDICs are fully pipelined.
// The pipeline advances whenever the output register is empty or being taken.
// Reset (rst_n, synchronous, active low) clears valid bits and radial_mode; no clearing pass.
module rotated_sprite_quad_vertices #(
  parameter int COORD_BITS = rsqv_pkg::COORD_BITS_DEF,
  parameter int ANGLE_BITS = rsqv_pkg::ANGLE_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic cfg_wdata,
  input  logic in_tvalid,
  output logic in_tready,
  // center_x, center_y, edge_length, spin_angle (low bit up)
  input  logic [((3*COORD_BITS+ANGLE_BITS-1+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // bl_x, bl_y, br_x, br_y, tl_x, tl_y, tr_x, tr_y (low bit up)
  output logic [((8*COORD_BITS+7)/8)*8-1:0] out_tdata
);
  import rsqv_pkg::*;
  localparam int OW = ((8*COORD_BITS+7)/8)*8;
  // atan2 (N stages) plus sin/cos (N stages and the clamp register)
  localparam int LAT = 2*CORDIC_STEPS + 3;

  logic radial_mode_r;
  always_ff @(posedge clk) begin
    if (!rst_n) radial_mode_r <= 1'b0;
    else if (cfg_we) radial_mode_r <= cfg_wdata;
  end

  logic en;
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  logic signed [COORD_BITS-1:0] cx, cy;
  logic [COORD_BITS-2:0] h;
  logic [ANGLE_BITS-1:0] spin;
  assign cx   = in_tdata[COORD_BITS-1:0];
  assign cy   = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign h    = in_tdata[3*COORD_BITS-2:2*COORD_BITS];
  assign spin = in_tdata[3*COORD_BITS+ANGLE_BITS-2:3*COORD_BITS-1];

  // side data delay line alongside both CORDICs
  logic signed [COORD_BITS-1:0] cxd_r [LAT];
  logic signed [COORD_BITS-1:0] cyd_r [LAT];
  logic        [COORD_BITS-2:0] hd_r  [LAT];
  always_ff @(posedge clk) begin
    if (en) begin
      cxd_r[0] <= cx;
      cyd_r[0] <= cy;
      hd_r[0]  <= h;
      for (int k = 1; k < LAT; k++) begin
        cxd_r[k] <= cxd_r[k-1];
        cyd_r[k] <= cyd_r[k-1];
        hd_r[k]  <= hd_r[k-1];
      end
    end
  end

  logic        a_vld, s_vld, c_vld;
  logic [31:0] theta;
  logic signed [31:0] cs, sn;
  logic [8*COORD_BITS-1:0] corners;

  rsqv_atan #(.COORD_BITS(COORD_BITS), .ANGLE_BITS(ANGLE_BITS)) u_atan (
    .clk, .rst_n, .en, .in_valid(in_tvalid), .radial(radial_mode_r),
    .cx, .cy, .spin, .out_valid(a_vld), .theta
  );

  rsqv_sincos u_sincos (
    .clk, .rst_n, .en, .in_valid(a_vld), .theta,
    .out_valid(s_vld), .cos_q30(cs), .sin_q30(sn)
  );

  rsqv_corners #(.COORD_BITS(COORD_BITS)) u_corners (
    .clk, .rst_n, .en, .in_valid(s_vld), .h(hd_r[LAT-1]),
    .cos_q30(cs), .sin_q30(sn), .cx(cxd_r[LAT-1]), .cy(cyd_r[LAT-1]),
    .out_valid(c_vld), .corners
  );

  logic out_tvalid_r;
  logic [OW-1:0] out_tdata_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid_r <= 1'b0;
    else if (en) out_tvalid_r <= c_vld;
  end
  always_ff @(posedge clk) begin
    if (en) out_tdata_r <= OW'(corners);
  end
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> radial_mode_r == $past(cfg_wdata))
    else $error("radial_mode write lost");
endmodule

>>> bench/rotated_sprite_quad_vertices_test.sv
// Testbench for the sprite quad corner pipeline: directed table, random particles, scoreboard.
`timescale 1ns / 1ps

module rotated_sprite_quad_vertices_test;
  import rsqv_pkg::*;

  localparam int CB = 24;
  localparam int AB = 16;
  localparam int IN_W = ((3*CB+AB-1+7)/8)*8;
  localparam int OUT_W = ((8*CB+7)/8)*8;
  localparam int PIPE_LAT = 63;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [AB-1:0] spin;
    logic [CB-2:0] edge_len;
    logic signed [CB-1:0] cy;
    logic signed [CB-1:0] cx;
  } particle_t;

  typedef struct {
    particle_t p;
    bit has_corners;
    logic [OUT_W-1:0] corners;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  logic in_tvalid;
  logic in_tready;
  logic [IN_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_W-1:0] out_tdata;

  rotated_sprite_quad_vertices uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  logic [OUT_W-1:0] corner_queue[$];
  bit radial_on;
  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int results_seen;
  int items_sent;
  longint cycles;

  localparam longint ATAN_TAB[CORDIC_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor shift, safe for negatives
  function automatic longint floor_shr(longint v, int s);
    if (v >= 0) return v >>> s;
    return -64'sd1 - ((-64'sd1 - v) >>> s);
  endfunction

  function automatic void rotate_unit(logic [31:0] phi, output longint c, output longint s);
    bit flip;
    longint x, y, z, dx, dy;
    flip = 0;
    x = 652032874;
    y = 0;
    if (phi[31:30] == 2'd1 || phi[31:30] == 2'd2) begin
      phi = phi + 32'h8000_0000;
      flip = 1;
    end
    z = longint'($signed(phi));
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end
    end
    if (x > 1073741824) x = 1073741824;
    if (x < -1073741824) x = -1073741824;
    if (y > 1073741824) y = 1073741824;
    if (y < -1073741824) y = -1073741824;
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [31:0] heading_of(longint a, longint b);
    longint u, v, z, du, dv;
    if (a == 0 && b == 0) return 32'd0;
    u = b * (64'sd1 << 29);
    v = a * (64'sd1 << 29);
    z = 0;
    if (u < 0) begin
      u = -u; v = -v; z = 64'sh8000_0000;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      du = floor_shr(v, i);
      dv = floor_shr(u, i);
      if (v > 0) begin
        u += du; v -= dv; z += ATAN_TAB[i];
      end else begin
        u -= du; v += dv; z -= ATAN_TAB[i];
      end
    end
    return z[31:0];
  endfunction

  function automatic logic [CB-1:0] place_corner(longint center, longint off);
    longint t, r, v;
    t = off + (64'sd1 << 30);
    if (t >= 0) r = t >>> 31;
    else r = -((-t + ((64'sd1 << 31) - 1)) >>> 31);
    v = center + r;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[CB-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] quad_corners(particle_t p, bit radial);
    longint cx, cy, h, c, s, pc, qs;
    logic [31:0] theta;
    cx = longint'(p.cx);
    cy = longint'(p.cy);
    h = longint'({1'b0, p.edge_len});
    theta = radial ? heading_of(cx, cy) : {p.spin, 16'd0};
    rotate_unit(32'd0 - theta, c, s);
    pc = h * c;
    qs = h * s;
    return {place_corner(cy, pc + qs), place_corner(cx, pc - qs),
            place_corner(cy, pc - qs), place_corner(cx, -(pc + qs)),
            place_corner(cy, qs - pc), place_corner(cx, pc + qs),
            place_corner(cy, -(pc + qs)), place_corner(cx, qs - pc)};
  endfunction

  // result side: random stall, check in order
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (corner_queue.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result %h", out_tdata);
        end else begin
          if (corner_queue[0] !== out_tdata) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              for (int k = 0; k < 8; k++)
                if (corner_queue[0][k*CB +: CB] !== out_tdata[k*CB +: CB])
                  $display("corner field %0d: expected %h got %h", k,
                           corner_queue[0][k*CB +: CB], out_tdata[k*CB +: CB]);
          end
          void'(corner_queue.pop_front());
        end
      end
    end
  end

  initial begin
    wait (cycles > CYCLE_LIMIT);
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end

  // in_tvalid stays high into the next call; idle cycles and drains drop it
  task automatic send_particle(particle_t p, bit has_fixed, logic [OUT_W-1:0] fixed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_W'(p);
    do @(posedge clk); while (!in_tready);
    corner_queue.push_back(has_fixed ? fixed : quad_corners(p, radial_on));
    items_sent++;
  endtask

  task automatic drain_pipe();
    in_tvalid <= 1'b0;
    while (corner_queue.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 8) @(posedge clk);
  endtask

  task automatic set_radial(bit v);
    drain_pipe();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    radial_on = v;
  endtask

  function automatic particle_t rand_particle();
    particle_t p;
    p.cx = CB'($urandom);
    p.cy = CB'($urandom);
    p.edge_len = (CB-1)'($urandom);
    p.spin = AB'($urandom);
    case ($urandom_range(3))
      0: begin
        p.cx = CB'($signed(24'($urandom_range(8192))) - 4096);
        p.cy = CB'($signed(24'($urandom_range(8192))) - 4096);
        p.edge_len = (CB-1)'($urandom_range(4096));
      end
      1: p.spin = {2'($urandom_range(3)), 14'd0};
      default: ;
    endcase
    return p;
  endfunction

  dir_row_t dir_rows[$];

  initial begin
    dir_row_t r;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    mismatches = 0;
    results_seen = 0;
    items_sent = 0;
    cycles = 0;
    radial_on = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table; zero-size rows just echo the centre
    r.p = '{spin: 16'h0, edge_len: 23'd0, cy: 24'sd0, cx: 24'sd0};
    r.has_corners = 1; r.corners = '0; dir_rows.push_back(r);
    r.p = '{spin: 16'h1234, edge_len: 23'd0, cy: 24'sh7fffff, cx: -24'sh800000};
    r.corners = {4{24'h7fffff, 24'h800000}}; dir_rows.push_back(r);
    r.p = '{spin: 16'hffff, edge_len: 23'd0, cy: -24'sh800000, cx: 24'sh7fffff};
    r.corners = {4{24'h800000, 24'h7fffff}}; dir_rows.push_back(r);
    r.has_corners = 0;
    r.p = '{spin: 16'h0, edge_len: 23'h7fffff, cy: 24'sh7fffff, cx: 24'sh7fffff};
    dir_rows.push_back(r);
    r.p = '{spin: 16'h8000, edge_len: 23'h7fffff, cy: -24'sh800000, cx: -24'sh800000};
    dir_rows.push_back(r);
    foreach (ATAN_TAB[k]) if (k < 8) begin
      r.p = '{spin: 16'(k * 16'h2000 + k), edge_len: 23'd512, cy: 24'sd100, cx: -24'sd100};
      dir_rows.push_back(r);
    end
    r.p = '{spin: 16'h4000, edge_len: 23'd1, cy: 24'sd0, cx: 24'sd0};
    dir_rows.push_back(r);
    r.p = '{spin: 16'hc000, edge_len: 23'd3, cy: 24'sd1, cx: -24'sd1};
    dir_rows.push_back(r);

    foreach (dir_rows[k]) send_particle(dir_rows[k].p, dir_rows[k].has_corners,
                                        dir_rows[k].corners);

    // radial mode corner cases: zero centre, axes, extremes
    set_radial(1);
    send_particle('{spin: 16'h5555, edge_len: 23'd0, cy: 24'sd0, cx: 24'sd0}, 1, '0);
    send_particle('{spin: 16'h1111, edge_len: 23'd1024, cy: 24'sd0, cx: 24'sd0}, 0, '0);
    send_particle('{spin: 16'h0, edge_len: 23'd512, cy: 24'sd0, cx: 24'sd300}, 0, '0);
    send_particle('{spin: 16'h0, edge_len: 23'd512, cy: -24'sd300, cx: 24'sd0}, 0, '0);
    send_particle('{spin: 16'hffff, edge_len: 23'h7fffff, cy: -24'sh800000,
                    cx: -24'sh800000}, 0, '0);
    send_particle('{spin: 16'h0, edge_len: 23'h7fffff, cy: 24'sh7fffff,
                    cx: 24'sh7fffff}, 0, '0);

    // random phases, register toggled between them
    for (int ph = 0; ph < 6; ph++) begin
      set_radial(ph[0]);
      send_idle_pct = (ph < 2) ? 32 : (ph < 4) ? 63 : 0;
      recv_idle_pct = (ph < 2) ? 63 : (ph < 4) ? 32 : 0;
      for (int n = 0; n < 210; n++) begin
        if (n == 100) drain_pipe();
        send_particle(rand_particle(), 0, '0);
      end
    end

    in_tvalid <= 1'b0;
    while (corner_queue.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 8) @(posedge clk);
    $display("%0d particles sent, %0d quads checked in both orientation modes",
             items_sent, results_seen);
    if (mismatches == 0 && corner_queue.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
